@@ hw/rtl/hpdc_pkg.sv @@
// Shared types and constants for the helix pair duplicate classifier.
package hpdc_pkg;

    localparam int D0_W    = 16;
    localparam int PHI_W   = 16;
    localparam int KAPPA_W = 20;
    localparam int KMAG_W  = 20;
    localparam int KSUM_W  = 21;
    localparam int RATIO_W = 16;
    localparam int FLOOR_W = 19;
    localparam int TOL_W   = 15;
    localparam int PROD_W  = RATIO_W + KSUM_W;
    localparam int LHS_W   = KMAG_W + 16;
    localparam int ADDR_W  = 4;

    localparam logic [PHI_W-1:0] QUARTER_TURN   = 16'd16384;
    localparam logic [PHI_W:0]   HALF_TURN      = 17'd32768;
    localparam logic [D0_W:0]    SUM_D0_LIMIT   = 17'd1024;
    localparam logic [D0_W-1:0]  DIFF_D0_ALBEDO = 16'd12032;

    localparam logic [TOL_W-1:0]   RST_MAX_D0_DIFF      = 15'd691;
    localparam logic [TOL_W-1:0]   RST_MAX_PHI_DIFF     = 15'd1565;
    localparam logic [RATIO_W-1:0] RST_MAX_RADIUS_RATIO = 16'd14418;
    localparam logic [FLOOR_W-1:0] RST_KAPPA_FLOOR      = 19'd14;

    typedef enum logic [1:0] {
        REG_MAX_D0_DIFF      = 2'd0,
        REG_MAX_PHI_DIFF     = 2'd1,
        REG_MAX_RADIUS_RATIO = 2'd2,
        REG_KAPPA_FLOOR      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLS_DISTINCT  = 2'd0,
        CLS_DUPLICATE = 2'd1,
        CLS_ALBEDO    = 2'd2
    } t_pair_class;

    typedef struct packed {
        logic [TOL_W-1:0]   max_d0_diff;
        logic [TOL_W-1:0]   max_phi_diff;
        logic [RATIO_W-1:0] max_radius_ratio;
        logic [FLOOR_W-1:0] kappa_floor;
    } t_cfg;

    typedef struct packed {
        logic [D0_W-1:0]   dd0;
        logic [D0_W:0]     sd0;
        logic [PHI_W-1:0]  dphi;
        logic [KMAG_W-1:0] kmag_a;
        logic [KMAG_W-1:0] kmag_b;
        logic              same;
        logic              opp;
    } t_prep;

    typedef struct packed {
        logic              dup_win;
        logic              alb_win;
        logic [KMAG_W-1:0] kdiff;
        logic [KSUM_W-1:0] ksum;
    } t_gate;

    typedef struct packed {
        logic              dup_win;
        logic              alb_win;
        logic [LHS_W-1:0]  lhs;
        logic [PROD_W-1:0] prod;
    } t_radius;

endpackage

@@ hw/rtl/hpdc_prep.sv @@
// Stage one: shifted azimuth gap, d0 difference and sum, curvature magnitudes and signs.
module hpdc_prep import hpdc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [D0_W-1:0]    i_ref_d0,
    input  logic [PHI_W-1:0]          i_ref_phi,
    input  logic signed [KAPPA_W-1:0] i_ref_kappa,
    input  logic signed [D0_W-1:0]    i_test_d0,
    input  logic [PHI_W-1:0]          i_test_phi,
    input  logic signed [KAPPA_W-1:0] i_test_kappa,
    output logic                      o_valid,
    output t_prep                     o_prep
);

    logic              r_valid;
    t_prep             r_prep;
    t_prep             n_prep;
    logic signed [D0_W:0]    w_diff;
    logic signed [D0_W:0]    w_sum;
    logic [PHI_W-1:0]        w_pa;
    logic [PHI_W-1:0]        w_pb;
    logic signed [KAPPA_W:0] w_ka;
    logic signed [KAPPA_W:0] w_kb;
    logic                    w_a_nz;
    logic                    w_b_nz;

    always_comb begin
        w_diff = {i_ref_d0[D0_W-1], i_ref_d0} - {i_test_d0[D0_W-1], i_test_d0};
        w_sum  = {i_ref_d0[D0_W-1], i_ref_d0} + {i_test_d0[D0_W-1], i_test_d0};
        w_pa   = i_ref_phi + QUARTER_TURN;
        w_pb   = i_test_phi + QUARTER_TURN;
        w_ka   = {i_ref_kappa[KAPPA_W-1], i_ref_kappa};
        w_kb   = {i_test_kappa[KAPPA_W-1], i_test_kappa};
        w_a_nz = |i_ref_kappa;
        w_b_nz = |i_test_kappa;

        n_prep.dd0  = w_diff[D0_W] ? D0_W'(-w_diff) : w_diff[D0_W-1:0];
        n_prep.sd0  = w_sum[D0_W] ? (D0_W+1)'(-w_sum) : w_sum;
        n_prep.dphi = (w_pa > w_pb) ? PHI_W'(w_pa - w_pb) : PHI_W'(w_pb - w_pa);
        n_prep.kmag_a = w_ka[KAPPA_W] ? KMAG_W'(-w_ka) : w_ka[KMAG_W-1:0];
        n_prep.kmag_b = w_kb[KAPPA_W] ? KMAG_W'(-w_kb) : w_kb[KMAG_W-1:0];
        n_prep.same = w_a_nz && w_b_nz && (i_ref_kappa[KAPPA_W-1] == i_test_kappa[KAPPA_W-1]);
        n_prep.opp  = w_a_nz && w_b_nz && (i_ref_kappa[KAPPA_W-1] != i_test_kappa[KAPPA_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;

endmodule

@@ hw/rtl/hpdc_gate.sv @@
// Stage two: curvature floor, curvature difference and sum, d0 and azimuth window tests.
module hpdc_gate import hpdc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_prep i_prep,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_gate o_gate
);

    logic              r_valid;
    t_gate             r_gate;
    t_gate             n_gate;
    logic [KMAG_W-1:0] w_floor;
    logic [KMAG_W-1:0] w_ka;
    logic [KMAG_W-1:0] w_kb;
    logic signed [PHI_W:0] w_half;
    logic [PHI_W-1:0]  w_half_abs;

    always_comb begin
        w_floor = {{(KMAG_W-FLOOR_W){1'b0}}, i_cfg.kappa_floor};
        w_ka    = (i_prep.kmag_a > w_floor) ? i_prep.kmag_a : w_floor;
        w_kb    = (i_prep.kmag_b > w_floor) ? i_prep.kmag_b : w_floor;
        w_half  = $signed({1'b0, i_prep.dphi}) - $signed(HALF_TURN);
        w_half_abs = w_half[PHI_W] ? PHI_W'(-w_half) : w_half[PHI_W-1:0];

        n_gate.kdiff = (w_ka > w_kb) ? (w_ka - w_kb) : (w_kb - w_ka);
        n_gate.ksum  = {1'b0, w_ka} + {1'b0, w_kb};
        n_gate.dup_win = i_prep.same
            && (i_prep.dd0 < {1'b0, i_cfg.max_d0_diff})
            && (i_prep.dphi < {1'b0, i_cfg.max_phi_diff});
        n_gate.alb_win = i_prep.opp
            && (i_prep.sd0 < SUM_D0_LIMIT)
            && (i_prep.dd0 > DIFF_D0_ALBEDO)
            && (w_half_abs < {1'b0, i_cfg.max_phi_diff});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gate <= n_gate;
        end
    end

    assign o_valid = r_valid;
    assign o_gate  = r_gate;

endmodule

@@ hw/rtl/hpdc_radius.sv @@
// Stage three: ratio limit times curvature sum, scaled curvature difference.
module hpdc_radius import hpdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_gate   i_gate,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_radius o_radius
);

    logic    r_valid;
    t_radius r_radius;
    t_radius n_radius;

    always_comb begin
        n_radius.dup_win = i_gate.dup_win;
        n_radius.alb_win = i_gate.alb_win;
        n_radius.lhs     = {i_gate.kdiff, 16'd0};
        n_radius.prod    = {{KSUM_W{1'b0}}, i_cfg.max_radius_ratio}
                         * {{RATIO_W{1'b0}}, i_gate.ksum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= n_radius;
        end
    end

    assign o_valid  = r_valid;
    assign o_radius = r_radius;

endmodule

@@ hw/rtl/helix_pair_duplicate_classifier_top.sv @@
// Top level: configuration registers, three-stage classifier pipeline and output register.
//
// Input channel: one beat carries a reference track and a candidate track
// (d0, azimuth, signed curvature each); accepted when i_valid and o_ready.
// Output channel: one beat per input beat carrying o_pair_class
// (0 distinct, 1 same-charge duplicate, 2 opposite-charge albedo);
// taken when o_valid and i_ready.
// The beat passes the difference, window and multiplier stage registers,
// then the final compare into the output register.
// Throughput: one beat per cycle while the receiver keeps i_ready high.
// Each stage carries its own valid bit and loads when empty or when the
// stage after it moves, so bubbles close up and a stalled receiver only
// backs up the pipeline; o_ready drops when all four stages are full and i_ready is low.
// Reset clears every valid bit and restores the register reset values.
// Configuration: APB write at byte address 4*index, pready always high;
// write only while the pipeline is empty.
module helix_pair_duplicate_classifier_top import hpdc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [D0_W-1:0]    i_ref_d0,
    input  logic [PHI_W-1:0]          i_ref_phi,
    input  logic signed [KAPPA_W-1:0] i_ref_kappa,
    input  logic signed [D0_W-1:0]    i_test_d0,
    input  logic [PHI_W-1:0]          i_test_phi,
    input  logic signed [KAPPA_W-1:0] i_test_kappa,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_pair_class,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    t_cfg        r_cfg;
    t_reg_idx    w_idx;
    logic        w_wr;
    logic        r_out_valid;
    logic [1:0]  r_out_class;
    logic [1:0]  n_out_class;
    logic        w_rad_ok;
    logic        w_en_out;
    logic        w_en_rad;
    logic        w_en_gate;
    logic        w_en_prep;
    logic        w_prep_valid;
    logic        w_gate_valid;
    logic        w_rad_valid;
    t_prep       w_prep;
    t_gate       w_gate;
    t_radius     w_radius;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_d0_diff      <= RST_MAX_D0_DIFF;
            r_cfg.max_phi_diff     <= RST_MAX_PHI_DIFF;
            r_cfg.max_radius_ratio <= RST_MAX_RADIUS_RATIO;
            r_cfg.kappa_floor      <= RST_KAPPA_FLOOR;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_D0_DIFF:      r_cfg.max_d0_diff      <= pwdata[TOL_W-1:0];
                REG_MAX_PHI_DIFF:     r_cfg.max_phi_diff     <= pwdata[TOL_W-1:0];
                REG_MAX_RADIUS_RATIO: r_cfg.max_radius_ratio <= pwdata[RATIO_W-1:0];
                REG_KAPPA_FLOOR:      r_cfg.kappa_floor      <= pwdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_D0_DIFF:      prdata = {{(32-TOL_W){1'b0}}, r_cfg.max_d0_diff};
            REG_MAX_PHI_DIFF:     prdata = {{(32-TOL_W){1'b0}}, r_cfg.max_phi_diff};
            REG_MAX_RADIUS_RATIO: prdata = {{(32-RATIO_W){1'b0}}, r_cfg.max_radius_ratio};
            REG_KAPPA_FLOOR:      prdata = {{(32-FLOOR_W){1'b0}}, r_cfg.kappa_floor};
            default:              prdata = 32'd0;
        endcase
    end

    // stage loads when empty or when the next stage moves
    assign w_en_out  = !r_out_valid || i_ready;
    assign w_en_rad  = !w_rad_valid || w_en_out;
    assign w_en_gate = !w_gate_valid || w_en_rad;
    assign w_en_prep = !w_prep_valid || w_en_gate;
    assign o_ready   = w_en_prep;

    hpdc_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en_prep),
        .i_valid      (i_valid),
        .i_ref_d0     (i_ref_d0),
        .i_ref_phi    (i_ref_phi),
        .i_ref_kappa  (i_ref_kappa),
        .i_test_d0    (i_test_d0),
        .i_test_phi   (i_test_phi),
        .i_test_kappa (i_test_kappa),
        .o_valid      (w_prep_valid),
        .o_prep       (w_prep)
    );

    hpdc_gate u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en_gate),
        .i_valid (w_prep_valid),
        .i_prep  (w_prep),
        .i_cfg   (r_cfg),
        .o_valid (w_gate_valid),
        .o_gate  (w_gate)
    );

    hpdc_radius u_radius (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en_rad),
        .i_valid  (w_gate_valid),
        .i_gate   (w_gate),
        .i_cfg    (r_cfg),
        .o_valid  (w_rad_valid),
        .o_radius (w_radius)
    );

    always_comb begin
        w_rad_ok = {1'b0, w_radius.lhs} < w_radius.prod;
        if (w_radius.alb_win && w_rad_ok) begin
            n_out_class = CLS_ALBEDO;
        end else if (w_radius.dup_win && w_rad_ok) begin
            n_out_class = CLS_DUPLICATE;
        end else begin
            n_out_class = CLS_DISTINCT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_rad_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_class <= n_out_class;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pair_class = r_out_class;

endmodule

@@ tb/helix_pair_duplicate_classifier_top_tb.sv @@
// Self-checking testbench for the helix pair duplicate classifier top level.
`timescale 1ns / 1ps

module helix_pair_duplicate_classifier_top_tb import hpdc_pkg::*;;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        logic signed [D0_W-1:0]    d0a;
        logic [PHI_W-1:0]          phia;
        logic signed [KAPPA_W-1:0] ka;
        logic signed [D0_W-1:0]    d0b;
        logic [PHI_W-1:0]          phib;
        logic signed [KAPPA_W-1:0] kb;
    } t_track_pair;

    typedef struct {
        bit          is_cfg;
        t_reg_idx    cfg_reg;
        logic [31:0] cfg_val;
        t_track_pair pair;
        bit          typed;
        t_pair_class cls;
    } t_plan_step;

    typedef struct {
        int unsigned seq;
        t_pair_class cls;
    } t_due;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [D0_W-1:0]    i_ref_d0;
    logic [PHI_W-1:0]          i_ref_phi;
    logic signed [KAPPA_W-1:0] i_ref_kappa;
    logic signed [D0_W-1:0]    i_test_d0;
    logic [PHI_W-1:0]          i_test_phi;
    logic signed [KAPPA_W-1:0] i_test_kappa;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [1:0]                o_pair_class;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    t_cfg        cfg_now;
    t_due        class_due[$];
    t_due        head;
    t_plan_step  plan[$];
    int unsigned mismatches = 0;
    int unsigned pairs_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    bit          calm = 1'b0;

    helix_pair_duplicate_classifier_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ref_d0     (i_ref_d0),
        .i_ref_phi    (i_ref_phi),
        .i_ref_kappa  (i_ref_kappa),
        .i_test_d0    (i_test_d0),
        .i_test_phi   (i_test_phi),
        .i_test_kappa (i_test_kappa),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pair_class (o_pair_class),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_pair_class classify_pair(input t_cfg c, input t_track_pair p);
        longint pa, pb, ca, cb, dd0, sd0, dphi, ma, mb;
        bit rad_ok, same, opp;
        t_pair_class cls;
        pa = (longint'(p.phia) + longint'(QUARTER_TURN)) % 65536;
        pb = (longint'(p.phib) + longint'(QUARTER_TURN)) % 65536;
        ca = p.ka;
        cb = p.kb;
        dd0 = abs_l(longint'(p.d0a) - longint'(p.d0b));
        sd0 = abs_l(longint'(p.d0a) + longint'(p.d0b));
        dphi = abs_l(pa - pb);
        ma = abs_l(ca);
        mb = abs_l(cb);
        if (ma < longint'(c.kappa_floor)) ma = longint'(c.kappa_floor);
        if (mb < longint'(c.kappa_floor)) mb = longint'(c.kappa_floor);
        rad_ok = (abs_l(ma - mb) * 65536) < longint'(c.max_radius_ratio) * (ma + mb);
        same = (ca > 0 && cb > 0) || (ca < 0 && cb < 0);
        opp = (ca > 0 && cb < 0) || (ca < 0 && cb > 0);
        cls = CLS_DISTINCT;
        if (same && dd0 < longint'(c.max_d0_diff) && dphi < longint'(c.max_phi_diff) && rad_ok)
            cls = CLS_DUPLICATE;
        if (opp && sd0 < longint'(SUM_D0_LIMIT) && dd0 > longint'(DIFF_D0_ALBEDO) &&
            abs_l(dphi - longint'(HALF_TURN)) < longint'(c.max_phi_diff) && rad_ok)
            cls = CLS_ALBEDO;
        return cls;
    endfunction

    function automatic logic signed [D0_W-1:0] clamp_d0(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return D0_W'(v);
    endfunction

    function automatic logic signed [KAPPA_W-1:0] clamp_kappa(input longint v);
        if (v > 524287) return 20'sh7FFFF;
        if (v < -524288) return 20'sh80000;
        return KAPPA_W'(v);
    endfunction

    function automatic longint jitter(input longint n);
        return longint'($urandom_range(0, int'(2 * n))) - n;
    endfunction

    function automatic longint edge_d0();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic longint edge_phi();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 65535;
            2: return 16384;
            3: return 49151;
            default: return 49152;
        endcase
    endfunction

    function automatic longint edge_kappa();
        case ($urandom_range(0, 5))
            0: return -524288;
            1: return 524287;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return 14;
        endcase
    endfunction

    // Mostly near-duplicate and near-albedo pairs around the current windows.
    function automatic t_track_pair random_pair(input t_cfg c);
        t_track_pair p;
        longint m;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        p.d0a = D0_W'($urandom);
        p.phia = PHI_W'($urandom);
        p.d0b = D0_W'($urandom);
        p.phib = PHI_W'($urandom);
        p.ka = KAPPA_W'($urandom);
        p.kb = KAPPA_W'($urandom);
        m = longint'($urandom_range(1, 1 << $urandom_range(1, 19)));
        if (mode <= 6) p.ka = clamp_kappa($urandom_range(0, 1) ? m : -m);
        if (mode <= 3) begin
            p.d0b = clamp_d0(longint'(p.d0a) + jitter(longint'(c.max_d0_diff) + 4));
            p.phib = PHI_W'(longint'(p.phia) + jitter(longint'(c.max_phi_diff) + 4));
            p.kb = clamp_kappa(longint'(p.ka) + jitter(abs_l(p.ka) / 3 + 16));
        end else if (mode <= 6) begin
            m = longint'($urandom_range(6000, 16000));
            p.d0a = clamp_d0($urandom_range(0, 1) ? m : -m);
            p.d0b = clamp_d0(-longint'(p.d0a) + jitter(1100));
            p.phib = PHI_W'(longint'(p.phia) + 32768 + jitter(longint'(c.max_phi_diff) + 4));
            p.kb = clamp_kappa(-longint'(p.ka) + jitter(abs_l(p.ka) / 3 + 16));
        end else if (mode == 9) begin
            p.d0a = clamp_d0(edge_d0());
            p.d0b = clamp_d0(edge_d0());
            p.phia = PHI_W'(edge_phi());
            p.phib = PHI_W'(edge_phi());
            p.ka = clamp_kappa(edge_kappa());
            p.kb = clamp_kappa(edge_kappa());
        end
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic plan_pair(input longint d0a, input longint phia, input longint ka,
                             input longint d0b, input longint phib, input longint kb,
                             input bit typed, input t_pair_class cls);
        t_plan_step s;
        s.is_cfg = 1'b0;
        s.cfg_reg = REG_MAX_D0_DIFF;
        s.cfg_val = '0;
        s.pair.d0a = D0_W'(d0a);
        s.pair.phia = PHI_W'(phia);
        s.pair.ka = KAPPA_W'(ka);
        s.pair.d0b = D0_W'(d0b);
        s.pair.phib = PHI_W'(phib);
        s.pair.kb = KAPPA_W'(kb);
        s.typed = typed;
        s.cls = cls;
        plan = {plan, s};
    endtask

    task automatic plan_cfg(input t_reg_idx r, input logic [31:0] v);
        t_plan_step s;
        s.is_cfg = 1'b1;
        s.cfg_reg = r;
        s.cfg_val = v;
        s.pair = '{default: '0};
        s.typed = 1'b0;
        s.cls = CLS_DISTINCT;
        plan = {plan, s};
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic wait_drained();
        while (class_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx r, input logic [31:0] v);
        i_valid = 1'b0;
        wait_drained();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'({r, 2'b00});
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        case (r)
            REG_MAX_D0_DIFF:      cfg_now.max_d0_diff = v[TOL_W-1:0];
            REG_MAX_PHI_DIFF:     cfg_now.max_phi_diff = v[TOL_W-1:0];
            REG_MAX_RADIUS_RATIO: cfg_now.max_radius_ratio = v[RATIO_W-1:0];
            REG_KAPPA_FLOOR:      cfg_now.kappa_floor = v[FLOOR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_pair(input t_track_pair p, input bit typed, input t_pair_class cls);
        t_due d;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_ref_d0 = p.d0a;
        i_ref_phi = p.phia;
        i_ref_kappa = p.ka;
        i_test_d0 = p.d0b;
        i_test_phi = p.phib;
        i_test_kappa = p.kb;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        d.seq = pairs_sent;
        d.cls = typed ? cls : classify_pair(cfg_now, p);
        class_due = {class_due, d};
        pairs_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] d0_tol, input logic [31:0] phi_tol,
                             input logic [31:0] ratio, input logic [31:0] kfloor,
                             input int unsigned n_pairs);
        write_reg(REG_MAX_D0_DIFF, d0_tol);
        write_reg(REG_MAX_PHI_DIFF, phi_tol);
        write_reg(REG_MAX_RADIUS_RATIO, ratio);
        write_reg(REG_KAPPA_FLOOR, kfloor);
        repeat (n_pairs) begin
            if (!calm && $urandom_range(0, 99) == 0) begin
                i_valid = 1'b0;
                wait_drained();
            end
            send_pair(random_pair(cfg_now), 1'b0, CLS_DISTINCT);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (class_due.size() == 0) begin
                report_mismatch($sformatf("result beat %0d class %0d with nothing due",
                                          results_seen, o_pair_class));
            end else begin
                head = class_due.pop_front();
                if (o_pair_class !== head.cls)
                    report_mismatch($sformatf("pair %0d class got %0d want %0d",
                                              head.seq, o_pair_class, head.cls));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results due", cycles, class_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ref_d0 = '0;
        i_ref_phi = '0;
        i_ref_kappa = '0;
        i_test_d0 = '0;
        i_test_phi = '0;
        i_test_kappa = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_now.max_d0_diff = RST_MAX_D0_DIFF;
        cfg_now.max_phi_diff = RST_MAX_PHI_DIFF;
        cfg_now.max_radius_ratio = RST_MAX_RADIUS_RATIO;
        cfg_now.kappa_floor = RST_KAPPA_FLOOR;

        // reset-value windows
        plan_pair(0, 0, 0, 0, 0, 0, 1, CLS_DISTINCT);
        plan_pair(100, 1000, 0, 100, 1000, 100, 1, CLS_DISTINCT);
        plan_pair(100, 1000, 2000, 100, 1000, 2000, 1, CLS_DUPLICATE);
        plan_pair(-100, 30000, -2000, -100, 30000, -2000, 1, CLS_DUPLICATE);
        plan_pair(6100, 0, 1000, -6100, 32768, -1000, 1, CLS_ALBEDO);
        plan_pair(-6100, 20000, -1000, 6100, 52768, 1000, 1, CLS_ALBEDO);
        plan_pair(6100, 0, 1000, -6100, 32768, 1000, 1, CLS_DISTINCT);
        plan_pair(32767, 65535, -524288, -32768, 0, 524287, 1, CLS_DISTINCT);
        plan_pair(-32768, 65535, -524288, -32768, 65535, -524288, 1, CLS_DUPLICATE);
        plan_pair(32767, 0, 524287, 32767, 0, 524287, 1, CLS_DUPLICATE);
        // azimuth wrap after the quarter-turn shift
        plan_pair(0, 49151, 500, 0, 49152, 500, 0, CLS_DISTINCT);
        plan_pair(0, 65535, 500, 0, 0, 500, 0, CLS_DISTINCT);
        // window boundaries
        plan_pair(0, 0, 800, 691, 0, 800, 0, CLS_DISTINCT);
        plan_pair(0, 0, 800, 0, 1564, 800, 0, CLS_DISTINCT);
        plan_pair(0, 0, 1000, 0, 0, 1600, 0, CLS_DISTINCT);
        plan_pair(0, 0, 1, 0, 0, 13, 0, CLS_DISTINCT);
        plan_pair(6100, 0, 900, -5077, 32768, -900, 0, CLS_DISTINCT);
        plan_pair(6100, 0, 900, -5076, 32768, -900, 0, CLS_DISTINCT);
        plan_pair(6016, 0, 900, -6016, 32768, -900, 0, CLS_DISTINCT);
        plan_pair(6100, 0, 900, -6100, 34332, -900, 0, CLS_DISTINCT);
        // no curvature floor
        plan_cfg(REG_KAPPA_FLOOR, 32'd0);
        plan_pair(0, 0, 1, 0, 0, 2, 0, CLS_DISTINCT);
        plan_pair(0, 0, 0, 0, 0, 0, 1, CLS_DISTINCT);
        // all windows wide open, upper data bits set
        plan_cfg(REG_MAX_D0_DIFF, 32'hFFFF_FFFF);
        plan_cfg(REG_MAX_PHI_DIFF, 32'hFFFF_FFFF);
        plan_cfg(REG_MAX_RADIUS_RATIO, 32'hFFFF_FFFF);
        plan_cfg(REG_KAPPA_FLOOR, 32'hFFFF_FFFF);
        plan_pair(-32768, 0, -3, 32767, 0, -3, 0, CLS_DISTINCT);
        plan_pair(0, 0, 100, 100, 30000, 50000, 0, CLS_DISTINCT);
        // all windows closed
        plan_cfg(REG_MAX_D0_DIFF, 32'd0);
        plan_cfg(REG_MAX_PHI_DIFF, 32'd0);
        plan_cfg(REG_MAX_RADIUS_RATIO, 32'd0);
        plan_cfg(REG_KAPPA_FLOOR, 32'd0);
        plan_pair(100, 1000, 2000, 100, 1000, 2000, 1, CLS_DISTINCT);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_reg(plan[i].cfg_reg, plan[i].cfg_val);
            else
                send_pair(plan[i].pair, plan[i].typed, plan[i].cls);
        end

        run_phase(32'd691, 32'd1565, 32'd14418, 32'd14, 140);
        run_phase(32'd32767, 32'd32767, 32'd65535, 32'd524287, 140);
        run_phase(32'd0, 32'd0, 32'd0, 32'd0, 140);
        run_phase($urandom, $urandom, $urandom, $urandom, 140);
        run_phase(32'd4000, 32'd6000, 32'd30000, 32'd2000, 140);
        calm = 1'b1;
        run_phase(32'd691, 32'd1565, 32'd14418, 32'd14, 140);

        i_valid = 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (class_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", class_due.size()));
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/hpdc_pkg.sv
hw/rtl/hpdc_prep.sv
hw/rtl/hpdc_gate.sv
hw/rtl/hpdc_radius.sv
hw/rtl/helix_pair_duplicate_classifier_top.sv
tb/helix_pair_duplicate_classifier_top_tb.sv
